FILE: rtl/cmst_pkg.sv
// Shared types, codes and default sizes for the counting multiset table.
package cmst_pkg;

   localparam int ENTRIES_DEFAULT    = 64;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int KEY_BITS       = 32;
   localparam int AMOUNT_BITS    = 16;
   localparam int KEY_COUNT_BITS = 16;
   localparam int TOTAL_OUT_BITS = 22;

   // operation codes; any other code behaves as a query
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK             = 2'd0;
   localparam logic [1:0] ST_REMOVE_ABSENT  = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL     = 2'd2;
   localparam logic [1:0] ST_COUNT_SATURATE = 2'd3;

   typedef struct packed {
      logic [1:0]                 operation;
      logic signed [KEY_BITS-1:0] key;
      logic [AMOUNT_BITS-1:0]     amount;
   } req_word_type;

   typedef struct packed {
      logic                      found;
      logic [KEY_COUNT_BITS-1:0] key_count;
      logic [TOTAL_OUT_BITS-1:0] total_count;
      logic [1:0]                status;
   } rsp_word_type;

   // command broadcast from the controller to every cell of the row
   typedef struct packed {
      logic capture;    // compare the probe key, latch match and free grant
      logic write_hit;  // matching cell loads the new count
      logic write_new;  // granted free cell loads key and count
   } cell_cmd_type;

endpackage

FILE: rtl/cmst_cell.sv
// One table slot: key and count storage, key compare and free-slot chain link.
module cmst_cell #(
   parameter int COUNT_BITS = cmst_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cmst_pkg::cell_cmd_type            cmd,
   input  logic [cmst_pkg::KEY_BITS-1:0]     probe_key,
   input  logic [cmst_pkg::KEY_BITS-1:0]     wr_key,
   input  logic [COUNT_BITS-1:0]             wr_count,
   input  logic                              free_below,
   output logic                              free_upto,
   output logic                              match,
   output logic                              grant,
   output logic [COUNT_BITS-1:0]             hit_count
);
   import cmst_pkg::*;

   logic [KEY_BITS-1:0]   key_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  match_ff;
   logic                  grant_ff;
   logic                  occupied;
   logic                  load;

   assign occupied  = (count_ff != '0);
   // pass "some free slot at or below here" on to the next cell
   assign free_upto = free_below | ~occupied;
   assign load      = (cmd.write_hit & match_ff) | (cmd.write_new & grant_ff);

   always_ff @(posedge clock) begin
      if (cmd.write_new && grant_ff) begin
         key_ff <= wr_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         match_ff <= 1'b0;
         grant_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            match_ff <= occupied && (key_ff == probe_key);
            grant_ff <= ~occupied & ~free_below;
         end
         if (load) begin
            count_ff <= wr_count;
         end
      end
   end

   assign match     = match_ff;
   assign grant     = grant_ff;
   assign hit_count = match_ff ? count_ff : '0;

endmodule

FILE: rtl/counting_multiset_table_core.sv
// Counting multiset table: a row of key/count cells with a shared update unit.
//
//   channel | direction | ports                          | payload
//   --------+-----------+--------------------------------+------------------
//   request | in        | req_valid, req_ready, req_word | operation,key,amount
//   result  | out       | rsp_valid, rsp_ready, rsp_word | found,key_count,
//           |           |                                | total_count,status
//
// When a word is accepted every cell compares the key and the free-slot chain
// picks the lowest free cell, and each cell latches its match and grant; once
// the result register is free the update unit forms the new count, writes it
// back into at most one cell and loads the result register.
// Reset clears all counts and the total; keys are not cleared.
// A waiting result is held in the output register; the write-back cycle
// waits until that register is free, and no new word is taken meanwhile.
module counting_multiset_table_core #(
   parameter int ENTRIES    = cmst_pkg::ENTRIES_DEFAULT,
   parameter int COUNT_BITS = cmst_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cmst_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cmst_pkg::rsp_word_type rsp_word
);
   import cmst_pkg::*;

   localparam int TOTAL_BITS = COUNT_BITS + $clog2(ENTRIES);
   localparam int AMT_W      = (COUNT_BITS > AMOUNT_BITS) ? COUNT_BITS : AMOUNT_BITS;
   localparam int KC_W       = (COUNT_BITS > KEY_COUNT_BITS) ? COUNT_BITS : KEY_COUNT_BITS;
   localparam int TOT_W      = (TOTAL_BITS > TOTAL_OUT_BITS) ? TOTAL_BITS : TOTAL_OUT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // request hold and control
   logic                   busy_ff;
   logic [1:0]             op_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [AMOUNT_BITS-1:0] amt_ff;
   logic [TOTAL_BITS-1:0]  total_ff;
   logic [TOTAL_BITS-1:0]  total_in;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_word_ff;
   rsp_word_type           rsp_word_in;

   logic accept;
   logic done;

   // cell row
   cell_cmd_type          cmd;
   logic [ENTRIES:0]      free_chain;
   logic [ENTRIES-1:0]    match_vec;
   logic [ENTRIES-1:0]    grant_vec;
   logic [COUNT_BITS-1:0] hit_count [ENTRIES];
   logic [COUNT_BITS-1:0] wr_count;

   // update unit
   logic                  hit_any;
   logic                  free_any;
   logic [COUNT_BITS-1:0] cnt_sel;
   logic [COUNT_BITS-1:0] room;
   logic [AMT_W-1:0]      amt_wide;
   logic                  sat;
   logic [COUNT_BITS-1:0] add_cnt;
   logic [COUNT_BITS-1:0] sum_cnt;
   logic [COUNT_BITS-1:0] rsp_cnt;
   logic [KC_W-1:0]       rsp_cnt_wide;
   logic [TOT_W-1:0]      total_wide;
   logic                  wr_hit;
   logic                  wr_new;
   logic [1:0]            status;

   assign req_ready = ~busy_ff;
   assign accept    = req_valid & req_ready;
   assign done      = busy_ff & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      cmd.capture   = accept;
      cmd.write_hit = done & wr_hit;
      cmd.write_new = done & wr_new;
   end

   assign free_chain[0] = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      cmst_cell #(
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .probe_key  (req_word.key),
         .wr_key     (key_ff),
         .wr_count   (wr_count),
         .free_below (free_chain[i]),
         .free_upto  (free_chain[i+1]),
         .match      (match_vec[i]),
         .grant      (grant_vec[i]),
         .hit_count  (hit_count[i])
      );
   end

   // gather the single matching count; non-matching cells drive zero
   always_comb begin
      cnt_sel = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         cnt_sel = cnt_sel | hit_count[i];
      end
   end

   assign hit_any  = |match_vec;
   assign free_any = |grant_vec;

   // clamp the addition at the top of the count; an absent key starts at zero
   assign room     = COUNT_MAX - cnt_sel;
   assign amt_wide = AMT_W'(amt_ff);
   assign sat      = amt_wide > AMT_W'(room);
   assign add_cnt  = sat ? room : COUNT_BITS'(amt_wide);
   assign sum_cnt  = cnt_sel + add_cnt;

   always_comb begin
      wr_hit   = 1'b0;
      wr_new   = 1'b0;
      wr_count = sum_cnt;
      total_in = total_ff;
      rsp_cnt  = cnt_sel;
      status   = ST_OK;
      case (op_ff)
         OP_ADD: begin
            if (hit_any) begin
               wr_hit   = 1'b1;
               total_in = total_ff + TOTAL_BITS'(add_cnt);
               rsp_cnt  = sum_cnt;
               status   = sat ? ST_COUNT_SATURATE : ST_OK;
            end else if (amt_ff != '0) begin
               if (!free_any) begin
                  status = ST_TABLE_FULL;
               end else begin
                  wr_new   = 1'b1;
                  total_in = total_ff + TOTAL_BITS'(add_cnt);
                  rsp_cnt  = sum_cnt;
                  status   = sat ? ST_COUNT_SATURATE : ST_OK;
               end
            end
         end
         OP_REMOVE: begin
            if (hit_any) begin
               wr_hit   = 1'b1;
               wr_count = cnt_sel - COUNT_BITS'(1);
               total_in = total_ff - TOTAL_BITS'(1);
               rsp_cnt  = cnt_sel - COUNT_BITS'(1);
            end else begin
               status = ST_REMOVE_ABSENT;
            end
         end
         default: begin
            rsp_cnt = cnt_sel;
         end
      endcase
   end

   assign rsp_cnt_wide = KC_W'(rsp_cnt);
   assign total_wide   = TOT_W'(total_in);

   always_comb begin
      rsp_word_in.found       = hit_any;
      rsp_word_in.key_count   = rsp_cnt_wide[KEY_COUNT_BITS-1:0];
      rsp_word_in.total_count = total_wide[TOTAL_OUT_BITS-1:0];
      rsp_word_in.status      = status;
   end

   // hold the request while the cells work on it
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_word.operation;
         key_ff <= req_word.key;
         amt_ff <= req_word.amount;
      end
      if (done) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
            total_ff     <= total_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTH
   // keys are distinct, so at most one cell may match
   a_single_match : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot0(match_vec))
      else $error("more than one cell matched the key");

   // the free chain grants at most one cell
   a_single_grant : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot0(grant_vec))
      else $error("more than one free cell granted");

   // a finished update always presents its result
   a_done_presents : assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff && !busy_ff)
      else $error("update finished without a result");

   // a present key never reports a remove of an absent key or a full table
   a_found_status : assert property (@(posedge clock) disable iff (reset)
      done && hit_any |-> status != ST_REMOVE_ABSENT && status != ST_TABLE_FULL)
      else $error("status contradicts found key");

   // the total moves only when an item finishes
   a_total_stable : assert property (@(posedge clock) disable iff (reset)
      !$past(done) && !$past(reset) |-> $stable(total_ff))
      else $error("total changed outside an update");
`endif

endmodule
